### src/psc_pkg.sv
// ----------------------------------------------------------------------------
// psc_pkg: shared definitions of the payload signature classifier
// Token dictionaries, result codes and the record handed from the byte
// scanner to the result stage.
// ----------------------------------------------------------------------------
`default_nettype none

package psc_pkg;

  localparam int NUM_TOKENS        = 22;
  localparam int TOK_MAX_LEN       = 10;
  localparam int DEF_MAX_TOKEN_LEN = 9;
  localparam int QUEUE_DEPTH       = 2;

  localparam int REQ_FIRST  = 0;
  localparam int REQ_COUNT  = 12;
  localparam int FAM1_FIRST = 12;
  localparam int FAM1_COUNT = 4;
  localparam int FAM2_FIRST = 16;
  localparam int FAM2_COUNT = 6;

  localparam logic [7:0] EOT_BYTE = 8'h04;

  localparam logic [1:0] DIR_UNKNOWN  = 2'd0;
  localparam logic [1:0] DIR_REQUEST  = 2'd1;
  localparam logic [1:0] DIR_RESPONSE = 2'd2;

  localparam logic [1:0] PROTO_NONE = 2'd0;
  localparam logic [1:0] PROTO_FAM1 = 2'd1;
  localparam logic [1:0] PROTO_FAM2 = 2'd2;

  localparam logic [3:0] FWD_TYPE_LO = 4'd3;
  localparam logic [3:0] FWD_TYPE_HI = 4'd5;

  // Token text, first character in the most significant byte, zero padded.
  localparam logic [TOK_MAX_LEN*8-1:0] TOK_TEXT [NUM_TOKENS] = '{
    80'h1B00_0000_0000_0000_0000,
    80'h484F_0000_0000_0000_0000,
    80'h5243_5459_3143_0000_0000,
    80'h5253_454E_3041_0000_0000,
    80'h5241_4441_0000_0000_0000,
    80'h5344_4144_5300_0000_0000,
    80'h5344_4144_4500_0000_0000,
    80'h5344_4144_4300_0000_0000,
    80'h5344_4144_4200_0000_0000,
    80'h5253_5449_3143_0000_0000,
    80'h5353_4D50_3032_3032_4600,
    80'h5241_4443_3134_0000_0000,
    80'h5365_7276_6F2D_7330_0000,
    80'h5365_7276_6F2D_6930_0000,
    80'h5365_7276_6F2D_7331_0000,
    80'h5365_7276_6F2D_6931_0000,
    80'h5365_7276_6F2D_7530_0000,
    80'h5365_7276_6F2D_7531_0000,
    80'h5365_7276_6F2D_6E30_0000,
    80'h5365_7276_6F2D_6E31_0000,
    80'h5365_7276_6F2D_6169_7230,
    80'h5365_7276_6F2D_6169_7231
  };

  localparam int TOK_LEN [NUM_TOKENS] = '{
    1, 2, 6, 6, 4, 5, 5, 5, 5, 6, 9, 6,
    8, 8, 8, 8, 8, 8, 8, 8, 10, 10
  };

  typedef struct packed {
    logic                  empty;
    logic [NUM_TOKENS-1:0] pfx;
    logic [NUM_TOKENS-1:0] sub;
    logic                  eot;
    logic                  peer_req;
    logic [3:0]            peer_type;
  } rec_t;

  function automatic logic [7:0] tok_byte(input int t, input int i);
    logic [TOK_MAX_LEN*8-1:0] txt;
    txt = TOK_TEXT[t];
    return txt[TOK_MAX_LEN*8-1-8*i -: 8];
  endfunction

  // One-based position of the lowest set bit among the first count bits.
  function automatic logic [3:0] lowest_set(input logic [REQ_COUNT-1:0] mask,
                                            input int count);
    logic [3:0] hit;
    hit = 4'd0;
    for (int k = count - 1; k >= 0; k--) begin
      if (mask[k]) begin
        hit = 4'(k + 1);
      end
    end
    return hit;
  endfunction

endpackage

`default_nettype wire

### src/psc_if.sv
// ----------------------------------------------------------------------------
// psc_if: channel interfaces of the payload signature classifier
// Valid/ready channels for payload bytes in and classification results out.
// ----------------------------------------------------------------------------
`default_nettype none

interface psc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] payload_byte;
  logic       last_byte;
  logic       empty_payload;
  logic       peer_is_request;
  logic [3:0] peer_type;

  modport source (output valid, payload_byte, last_byte, empty_payload,
                  peer_is_request, peer_type, input ready);
  modport sink (input valid, payload_byte, last_byte, empty_payload,
                peer_is_request, peer_type, output ready);
endinterface

interface psc_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] direction;
  logic [1:0] proto_id;
  logic [3:0] type_id;
  logic [1:0] forward_target;

  modport source (output valid, direction, proto_id, type_id, forward_target,
                  input ready);
  modport sink (input valid, direction, proto_id, type_id, forward_target,
                output ready);
endinterface

`default_nettype wire

### src/payload_signature_classifier.sv
// ----------------------------------------------------------------------------
// payload_signature_classifier: packet payload classifier
// Input channel in_ch carries one payload byte per beat together with the
// last-byte and empty-payload marks and the peer flow's request flag and
// type. The output channel out_ch carries one classification result for
// each packet: direction, protocol family, type and forward target.
// Bytes are taken at one per cycle while the queue is not full; the scanner
// updates all token compares for each beat. A packet's result, also that
// of an empty-payload beat, passes through the record queue and then the
// result register before it is valid on out_ch.
// A two-entry queue sits between scanner and result stage, so bytes of the
// next packet keep flowing while a result waits. If the receiver holds
// ready low, the result register holds its beat, the queue fills, and
// in_ch.ready drops once two packet records are waiting.
// Reset clears the per-packet scan state, the queue and the output valid;
// in_ch.ready is high as soon as reset has cleared the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module payload_signature_classifier #(
  parameter int MAX_TOKEN_LEN = psc_pkg::DEF_MAX_TOKEN_LEN
) (
  input  wire logic clk,
  input  wire logic rst_n,
  psc_in_if.sink    in_ch,
  psc_out_if.source out_ch
);

  logic          q_push, q_full, q_pop, q_head_valid;
  psc_pkg::rec_t q_data, q_head;

  psc_front #(
    .MAX_TOKEN_LEN(MAX_TOKEN_LEN)
  ) u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .q_full (q_full),
    .q_push (q_push),
    .q_data (q_data)
  );

  psc_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_data  (q_data),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (q_head_valid),
    .head       (q_head)
  );

  psc_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_valid (q_head_valid),
    .head       (q_head),
    .pop        (q_pop),
    .out_ch     (out_ch)
  );

endmodule

`default_nettype wire

### src/psc_front.sv
// ----------------------------------------------------------------------------
// psc_front: payload byte scanner
// Tracks prefix agreement and substring hits of every token one byte per
// beat and pushes a packet record into the queue at the end of a packet.
// ----------------------------------------------------------------------------
`default_nettype none

module psc_front #(
  parameter int MAX_TOKEN_LEN = psc_pkg::DEF_MAX_TOKEN_LEN
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  psc_in_if.sink             in_ch,
  input  wire logic          q_full,
  output logic               q_push,
  output psc_pkg::rec_t      q_data
);

  localparam int NT       = psc_pkg::NUM_TOKENS;
  localparam int TL       = psc_pkg::TOK_MAX_LEN;
  localparam int HIST_LEN = (MAX_TOKEN_LEN > TL) ? MAX_TOKEN_LEN : TL;
  localparam int CNT_W    = $clog2(HIST_LEN + 1);

  logic [7:0]       hist_r   [HIST_LEN];
  logic [7:0]       hist_nxt [HIST_LEN];
  logic [NT-1:0]    pfx_r, pfx_nxt;
  logic [NT-1:0]    sub_r, sub_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             eot_r, eot_nxt;
  logic             accept;
  logic             same;
  logic [7:0]       b;

  assign in_ch.ready = !q_full;
  assign accept      = in_ch.valid && in_ch.ready;
  assign b           = in_ch.payload_byte;

  always_comb begin
    hist_nxt[0] = b;
    for (int k = 1; k < HIST_LEN; k++) begin
      hist_nxt[k] = hist_r[k-1];
    end
    cnt_nxt = (cnt_r < CNT_W'(HIST_LEN)) ? cnt_r + 1'b1 : cnt_r;
    eot_nxt = eot_r || (b == psc_pkg::EOT_BYTE);

    // Prefix agreement is checked at the position given by the byte count.
    pfx_nxt = pfx_r;
    for (int t = 0; t < NT; t++) begin
      for (int i = 0; i < TL; i++) begin
        if (i < psc_pkg::TOK_LEN[t] && cnt_r == CNT_W'(i) &&
            psc_pkg::tok_byte(t, i) != b) begin
          pfx_nxt[t] = 1'b0;
        end
      end
    end

    // Substring test: the newest bytes must end with the token.
    sub_nxt = sub_r;
    same    = 1'b0;
    for (int t = 0; t < NT; t++) begin
      same = (cnt_nxt >= CNT_W'(psc_pkg::TOK_LEN[t]));
      for (int k = 0; k < TL; k++) begin
        if (k < psc_pkg::TOK_LEN[t]) begin
          if (hist_nxt[k] != psc_pkg::tok_byte(t, psc_pkg::TOK_LEN[t] - 1 - k)) begin
            same = 1'b0;
          end
        end
      end
      if (same) begin
        sub_nxt[t] = 1'b1;
      end
    end
  end

  always_comb begin
    q_push           = accept && (in_ch.empty_payload || in_ch.last_byte);
    q_data.empty     = in_ch.empty_payload;
    q_data.pfx       = pfx_nxt;
    q_data.sub       = sub_nxt;
    q_data.eot       = eot_nxt;
    q_data.peer_req  = in_ch.peer_is_request;
    q_data.peer_type = in_ch.peer_type;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pfx_r <= '1;
      sub_r <= '0;
      cnt_r <= '0;
      eot_r <= 1'b0;
    end else if (accept) begin
      if (in_ch.empty_payload || in_ch.last_byte) begin
        pfx_r <= '1;
        sub_r <= '0;
        cnt_r <= '0;
        eot_r <= 1'b0;
      end else begin
        pfx_r <= pfx_nxt;
        sub_r <= sub_nxt;
        cnt_r <= cnt_nxt;
        eot_r <= eot_nxt;
      end
    end
  end

  // History bytes beyond the count are never compared, so they need no clear.
  always_ff @(posedge clk) begin
    if (accept && !in_ch.empty_payload) begin
      hist_r <= hist_nxt;
    end
  end

endmodule

`default_nettype wire

### src/psc_queue.sv
// ----------------------------------------------------------------------------
// psc_queue: packet record queue
// Short first-in first-out buffer between the byte scanner and the result
// stage.
// ----------------------------------------------------------------------------
`default_nettype none

module psc_queue (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          push,
  input  wire psc_pkg::rec_t push_data,
  output logic               full,
  input  wire logic          pop,
  output logic               head_valid,
  output psc_pkg::rec_t      head
);

  localparam int DEPTH = psc_pkg::QUEUE_DEPTH;
  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  psc_pkg::rec_t    mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0] count_r;
  logic             do_push, do_pop;

  assign full       = (count_r == CNT_W'(DEPTH));
  assign head_valid = (count_r != '0);
  assign head       = mem_r[rd_ptr_r];
  assign do_push    = push && !full;
  assign do_pop     = pop && head_valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + 1'b1;
      end else if (do_pop && !do_push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

### src/psc_back.sv
// ----------------------------------------------------------------------------
// psc_back: classification result stage
// Resolves a packet record by dictionary priority and holds the result in
// the output register until the receiver takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module psc_back (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          head_valid,
  input  wire psc_pkg::rec_t head,
  output logic               pop,
  psc_out_if.source          out_ch
);

  localparam int RF = psc_pkg::REQ_FIRST;
  localparam int RC = psc_pkg::REQ_COUNT;
  localparam int F1 = psc_pkg::FAM1_FIRST;
  localparam int C1 = psc_pkg::FAM1_COUNT;
  localparam int F2 = psc_pkg::FAM2_FIRST;
  localparam int C2 = psc_pkg::FAM2_COUNT;

  logic       valid_r;
  logic [1:0] dir_r, dir_nxt;
  logic [1:0] proto_r, proto_nxt;
  logic [3:0] type_r, type_nxt;
  logic [1:0] target_r, target_nxt;
  logic [3:0] req_pfx_hit, req_sub_hit, req_hit;
  logic       fam1_hit, fam2_hit;

  assign pop = head_valid && (!valid_r || out_ch.ready);

  always_comb begin
    req_pfx_hit = psc_pkg::lowest_set(head.pfx[RF +: RC], RC);
    req_sub_hit = psc_pkg::lowest_set(head.sub[RF +: RC], RC);
    req_hit     = (req_pfx_hit != 4'd0) ? req_pfx_hit : req_sub_hit;
    fam1_hit    = (|head.pfx[F1 +: C1]) || (|head.sub[F1 +: C1]);
    fam2_hit    = (|head.pfx[F2 +: C2]) || (|head.sub[F2 +: C2]);

    dir_nxt    = psc_pkg::DIR_UNKNOWN;
    proto_nxt  = psc_pkg::PROTO_NONE;
    type_nxt   = 4'd0;
    target_nxt = psc_pkg::PROTO_NONE;
    if (head.empty) begin
      dir_nxt = psc_pkg::DIR_UNKNOWN;
    end else if (req_hit != 4'd0) begin
      dir_nxt  = psc_pkg::DIR_REQUEST;
      type_nxt = req_hit;
    end else if (head.peer_req && (fam1_hit || fam2_hit)) begin
      dir_nxt   = psc_pkg::DIR_RESPONSE;
      proto_nxt = fam1_hit ? psc_pkg::PROTO_FAM1 : psc_pkg::PROTO_FAM2;
      type_nxt  = head.peer_type;
      if (head.peer_type >= psc_pkg::FWD_TYPE_LO &&
          head.peer_type <= psc_pkg::FWD_TYPE_HI) begin
        target_nxt = proto_nxt;
      end
    end else if (head.eot) begin
      dir_nxt = psc_pkg::DIR_REQUEST;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (pop) begin
      valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      dir_r    <= dir_nxt;
      proto_r  <= proto_nxt;
      type_r   <= type_nxt;
      target_r <= target_nxt;
    end
  end

  assign out_ch.valid          = valid_r;
  assign out_ch.direction      = dir_r;
  assign out_ch.proto_id       = proto_r;
  assign out_ch.type_id        = type_r;
  assign out_ch.forward_target = target_r;

endmodule

`default_nettype wire

### test/payload_signature_classifier_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// payload_signature_classifier_tb: self-checking bench of the classifier
// Packets go in one byte per beat with random gaps, and the result channel
// stalls at random. Every accepted beat is run through a local predictor
// of the token scan, and each result beat is compared with the oldest
// expectation. A directed table opens the run; random packets built from
// whole, cut and mixed tokens, noise and empty packets follow.
// ----------------------------------------------------------------------------

module payload_signature_classifier_tb;

  localparam int CYCLE_LIMIT   = 500000;
  localparam int RANDOM_BEATS  = 1100;
  localparam int LONG_HOLD     = 300;
  localparam int HOLD_AFTER    = 40;
  localparam int DRAIN_CYCLES  = 10;
  localparam int NUM_TOKENS    = psc_pkg::NUM_TOKENS;
  // The byte history must cover the longest token, which is longer than
  // the default maximum token length.
  localparam int HIST_DEPTH    = 10;

  typedef struct packed {
    logic [7:0] payload_byte;
    logic       last_byte;
    logic       empty_payload;
    logic       peer_is_request;
    logic [3:0] peer_type;
  } stim_beat_t;

  typedef struct packed {
    logic [1:0] direction;
    logic [1:0] proto_id;
    logic [3:0] type_id;
    logic [1:0] forward_target;
  } verdict_t;

  typedef struct packed {
    stim_beat_t beat;
    logic       pinned;
    verdict_t   want;
  } dir_row_t;

  localparam verdict_t NO_VERDICT = '0;

  // Token text, first character in the top byte, zero padded.
  localparam logic [79:0] SIG_TEXT [NUM_TOKENS] = '{
    80'h1B000000000000000000, 80'h484F0000000000000000,
    80'h52435459314300000000, 80'h5253454E304100000000,
    80'h52414441000000000000, 80'h53444144530000000000,
    80'h53444144450000000000, 80'h53444144430000000000,
    80'h53444144420000000000, 80'h52535449314300000000,
    80'h53534D50303230324600, 80'h52414443313400000000,
    80'h536572766F2D73300000, 80'h536572766F2D69300000,
    80'h536572766F2D73310000, 80'h536572766F2D69310000,
    80'h536572766F2D75300000, 80'h536572766F2D75310000,
    80'h536572766F2D6E300000, 80'h536572766F2D6E310000,
    80'h536572766F2D61697230, 80'h536572766F2D61697231
  };

  localparam int SIG_LEN [NUM_TOKENS] = '{
    1, 2, 6, 6, 4, 5, 5, 5, 5, 6, 9, 6, 8, 8, 8, 8, 8, 8, 8, 8, 10, 10
  };

  localparam int DIRECTED_ROWS = 20;
  localparam dir_row_t DIRECTED [DIRECTED_ROWS] = '{
    '{'{8'hFF, 1'b1, 1'b1, 1'b1, 4'd15}, 1'b1, NO_VERDICT},
    '{'{psc_pkg::EOT_BYTE, 1'b1, 1'b0, 1'b0, 4'd0}, 1'b1,
      '{psc_pkg::DIR_REQUEST, psc_pkg::PROTO_NONE, 4'd0, psc_pkg::PROTO_NONE}},
    '{'{8'hFF, 1'b1, 1'b0, 1'b1, 4'd15}, 1'b1, NO_VERDICT},
    '{'{8'h1B, 1'b1, 1'b0, 1'b0, 4'd7}, 1'b1,
      '{psc_pkg::DIR_REQUEST, psc_pkg::PROTO_NONE, 4'd1, psc_pkg::PROTO_NONE}},
    '{'{8'h48, 1'b0, 1'b0, 1'b1, 4'd3}, 1'b0, NO_VERDICT},
    '{'{8'h4F, 1'b1, 1'b0, 1'b1, 4'd3}, 1'b0, NO_VERDICT},
    // An empty mark in the middle of a packet, with no last byte.
    '{'{8'h52, 1'b0, 1'b0, 1'b1, 4'd0}, 1'b0, NO_VERDICT},
    '{'{8'h00, 1'b0, 1'b1, 1'b0, 4'd2}, 1'b1, NO_VERDICT},
    '{'{8'h53, 1'b0, 1'b0, 1'b1, 4'd13}, 1'b0, NO_VERDICT},
    '{'{8'h65, 1'b1, 1'b0, 1'b1, 4'd13}, 1'b0, NO_VERDICT},
    '{'{8'h53, 1'b0, 1'b0, 1'b0, 4'd3}, 1'b0, NO_VERDICT},
    '{'{8'h65, 1'b1, 1'b0, 1'b0, 4'd3}, 1'b0, NO_VERDICT},
    '{'{8'h53, 1'b0, 1'b0, 1'b1, 4'd5}, 1'b0, NO_VERDICT},
    '{'{8'h65, 1'b0, 1'b0, 1'b1, 4'd5}, 1'b0, NO_VERDICT},
    '{'{8'h72, 1'b0, 1'b0, 1'b1, 4'd5}, 1'b0, NO_VERDICT},
    '{'{8'h76, 1'b0, 1'b0, 1'b1, 4'd5}, 1'b0, NO_VERDICT},
    '{'{8'h6F, 1'b0, 1'b0, 1'b1, 4'd5}, 1'b0, NO_VERDICT},
    '{'{8'h2D, 1'b0, 1'b0, 1'b1, 4'd5}, 1'b0, NO_VERDICT},
    '{'{8'h75, 1'b1, 1'b0, 1'b1, 4'd5}, 1'b0, NO_VERDICT},
    '{'{8'h00, 1'b1, 1'b0, 1'b1, 4'd12}, 1'b1, NO_VERDICT}
  };

  logic clk;
  logic rst_n;

  psc_in_if  in_ch ();
  psc_out_if out_ch ();

  payload_signature_classifier dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // Scan state of the predictor.
  logic [7:0]            hist [HIST_DEPTH];
  logic [NUM_TOKENS-1:0] pfx_alive;
  logic [NUM_TOKENS-1:0] sub_seen;
  int                    seen_cnt;
  bit                    eot_flag;

  verdict_t pending_verdicts [$];
  int       failures;
  int       results_checked;
  int       beats_sent;
  int       cycle_count;

  initial begin
    clk = 1'b0;
  end

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic logic [7:0] sig_char(input int t, input int i);
    return SIG_TEXT[t][79-8*i -: 8];
  endfunction

  function automatic void clear_scan();
    for (int k = 0; k < HIST_DEPTH; k++) begin
      hist[k] = 8'h00;
    end
    pfx_alive = '1;
    sub_seen  = '0;
    seen_cnt  = 0;
    eot_flag  = 1'b0;
  endfunction

  function automatic void scan_byte(input logic [7:0] b);
    int  pos;
    bit  same;
    pos = seen_cnt;
    for (int t = 0; t < NUM_TOKENS; t++) begin
      if (pos < SIG_LEN[t] && sig_char(t, pos) != b) begin
        pfx_alive[t] = 1'b0;
      end
    end
    for (int k = HIST_DEPTH - 1; k > 0; k--) begin
      hist[k] = hist[k-1];
    end
    hist[0] = b;
    if (seen_cnt < HIST_DEPTH) begin
      seen_cnt++;
    end
    if (b == psc_pkg::EOT_BYTE) begin
      eot_flag = 1'b1;
    end
    // A token is seen once the newest bytes spell it, last character first.
    for (int t = 0; t < NUM_TOKENS; t++) begin
      same = (seen_cnt >= SIG_LEN[t]);
      for (int k = 0; k < SIG_LEN[t]; k++) begin
        if (same && sig_char(t, SIG_LEN[t] - 1 - k) != hist[k]) begin
          same = 1'b0;
        end
      end
      if (same) begin
        sub_seen[t] = 1'b1;
      end
    end
  endfunction

  function automatic int first_hit(input logic [NUM_TOKENS-1:0] mask, input int first,
                                   input int count);
    for (int k = 0; k < count; k++) begin
      if (mask[first+k]) begin
        return k + 1;
      end
    end
    return 0;
  endfunction

  function automatic int dict_search(input int first, input int count);
    int hit;
    hit = first_hit(pfx_alive, first, count);
    if (hit == 0) begin
      hit = first_hit(sub_seen, first, count);
    end
    return hit;
  endfunction

  // Returns 1 when the beat closes a packet, with its classification in v.
  function automatic bit classify_beat(input stim_beat_t b, output verdict_t v);
    int         hit;
    logic [1:0] fam;
    v = NO_VERDICT;
    if (b.empty_payload) begin
      clear_scan();
      return 1'b1;
    end
    scan_byte(b.payload_byte);
    if (!b.last_byte) begin
      return 1'b0;
    end
    hit = dict_search(psc_pkg::REQ_FIRST, psc_pkg::REQ_COUNT);
    if (hit != 0) begin
      v.direction = psc_pkg::DIR_REQUEST;
      v.type_id   = 4'(hit);
    end else begin
      fam = psc_pkg::PROTO_NONE;
      if (b.peer_is_request) begin
        if (dict_search(psc_pkg::FAM1_FIRST, psc_pkg::FAM1_COUNT) != 0) begin
          fam = psc_pkg::PROTO_FAM1;
        end else if (dict_search(psc_pkg::FAM2_FIRST, psc_pkg::FAM2_COUNT) != 0) begin
          fam = psc_pkg::PROTO_FAM2;
        end
      end
      if (fam != psc_pkg::PROTO_NONE) begin
        v.direction = psc_pkg::DIR_RESPONSE;
        v.proto_id  = fam;
        v.type_id   = b.peer_type;
        if (b.peer_type >= psc_pkg::FWD_TYPE_LO && b.peer_type <= psc_pkg::FWD_TYPE_HI) begin
          v.forward_target = fam;
        end
      end else if (eot_flag) begin
        v.direction = psc_pkg::DIR_REQUEST;
      end
    end
    clear_scan();
    return 1'b1;
  endfunction

  // Mostly short gaps, now and then a long one.
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 45) begin
      return 0;
    end else if (r < 90) begin
      return $urandom_range(1, 3);
    end else if (r < 97) begin
      return $urandom_range(4, 10);
    end
    return $urandom_range(20, 40);
  endfunction

  function automatic logic [7:0] noise_byte();
    int r;
    int t;
    r = $urandom_range(0, 99);
    if (r < 40) begin
      t = $urandom_range(0, NUM_TOKENS - 1);
      return sig_char(t, $urandom_range(0, SIG_LEN[t] - 1));
    end else if (r < 44) begin
      return psc_pkg::EOT_BYTE;
    end
    return 8'($urandom_range(0, 255));
  endfunction

  task automatic send_beat(input stim_beat_t b, input bit pinned, input verdict_t want,
                           input bit burst);
    int       gap;
    verdict_t v;
    gap = burst ? 0 : gap_len();
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid           <= 1'b1;
    in_ch.payload_byte    <= b.payload_byte;
    in_ch.last_byte       <= b.last_byte;
    in_ch.empty_payload   <= b.empty_payload;
    in_ch.peer_is_request <= b.peer_is_request;
    in_ch.peer_type       <= b.peer_type;
    do @(posedge clk); while (!in_ch.ready);
    beats_sent++;
    if (classify_beat(b, v)) begin
      pending_verdicts.push_back(pinned ? want : v);
    end
  endtask

  task automatic append_token(ref logic [7:0] body [$]);
    int t;
    int cut;
    t   = $urandom_range(0, NUM_TOKENS - 1);
    cut = ($urandom_range(0, 3) == 0) ? $urandom_range(1, SIG_LEN[t]) : SIG_LEN[t];
    for (int i = 0; i < cut; i++) begin
      body.push_back(sig_char(t, i));
    end
  endtask

  task automatic send_random_packet();
    logic [7:0] body [$];
    stim_beat_t b;
    int         kind;
    int         n;
    bit         burst;
    kind  = $urandom_range(0, 99);
    burst = ($urandom_range(0, 3) == 0);
    b.peer_is_request = ($urandom_range(0, 3) != 0);
    b.peer_type       = 4'($urandom_range(0, 15));
    b.empty_payload   = 1'b0;
    if (kind < 10) begin
      // Empty packet, sometimes cutting off bytes already sent.
      n = $urandom_range(0, 2) == 0 ? $urandom_range(1, 4) : 0;
      repeat (n) body.push_back(noise_byte());
    end else if (kind < 75) begin
      if ($urandom_range(0, 2) == 0) begin
        repeat ($urandom_range(1, 3)) body.push_back(noise_byte());
      end
      append_token(body);
      if (kind < 30) begin
        append_token(body);
      end
      if ($urandom_range(0, 1) == 0) begin
        repeat ($urandom_range(1, 3)) body.push_back(noise_byte());
      end
    end else if (kind < 88) begin
      // Long payload that runs the byte counter into saturation.
      repeat ($urandom_range(11, 30)) body.push_back(noise_byte());
      if ($urandom_range(0, 1) == 0) begin
        append_token(body);
      end
    end else begin
      repeat ($urandom_range(1, 6)) body.push_back(noise_byte());
    end
    foreach (body[i]) begin
      b.payload_byte = body[i];
      b.last_byte    = (kind >= 10) && (i == body.size() - 1);
      send_beat(b, 1'b0, NO_VERDICT, burst);
    end
    if (kind < 10) begin
      b.payload_byte  = 8'($urandom_range(0, 255));
      b.last_byte     = 1'($urandom_range(0, 1));
      b.empty_payload = 1'b1;
      send_beat(b, 1'b0, NO_VERDICT, burst);
    end
  endtask

  task automatic wait_all_results();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (pending_verdicts.size() != 0);
  endtask

  initial begin
    bit paused;
    rst_n                 <= 1'b0;
    in_ch.valid           <= 1'b0;
    in_ch.payload_byte    <= 8'h00;
    in_ch.last_byte       <= 1'b0;
    in_ch.empty_payload   <= 1'b0;
    in_ch.peer_is_request <= 1'b0;
    in_ch.peer_type       <= 4'd0;
    failures        = 0;
    results_checked = 0;
    beats_sent      = 0;
    paused          = 1'b0;
    clear_scan();
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    for (int r = 0; r < DIRECTED_ROWS; r++) begin
      send_beat(DIRECTED[r].beat, DIRECTED[r].pinned, DIRECTED[r].want, 1'b0);
    end
    wait_all_results();

    while (beats_sent < DIRECTED_ROWS + RANDOM_BEATS) begin
      if (!paused && beats_sent >= DIRECTED_ROWS + RANDOM_BEATS / 2) begin
        paused = 1'b1;
        wait_all_results();
      end
      send_random_packet();
    end

    wait_all_results();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (failures == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  // Result side: random stalls, and one long hold-off that backs the block
  // up into its input while beats keep being offered.
  initial begin
    bit held;
    int stall;
    held = 1'b0;
    out_ch.ready <= 1'b0;
    do @(posedge clk); while (!rst_n);
    forever begin
      if (!held && results_checked >= HOLD_AFTER) begin
        held = 1'b1;
        out_ch.ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
      end else begin
        out_ch.ready <= 1'b1;
        repeat (($urandom_range(0, 4) == 0) ? $urandom_range(30, 120)
                                            : $urandom_range(1, 8)) @(posedge clk);
        stall = gap_len();
        if (stall > 0) begin
          out_ch.ready <= 1'b0;
          repeat (stall) @(posedge clk);
        end
      end
    end
  end

  function automatic void check_field(input string name, input int want, input int got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      failures++;
    end
  endfunction

  always @(posedge clk) begin
    verdict_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_verdicts.size() == 0) begin
        $error("result beat with no packet waiting for one");
        failures++;
      end else begin
        want = pending_verdicts.pop_front();
        check_field("direction", int'(want.direction), int'(out_ch.direction));
        check_field("proto_id", int'(want.proto_id), int'(out_ch.proto_id));
        check_field("type_id", int'(want.type_id), int'(out_ch.type_id));
        check_field("forward_target", int'(want.forward_target),
                    int'(out_ch.forward_target));
      end
      results_checked++;
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  initial begin
    cycle_count = 0;
  end

endmodule
